>>> src/encoder_position_stop_controller_defines.svh
// Assertion macros used by the checker file of the stop controller.
// Standalone header; no dependencies.
`ifndef ENCODER_POSITION_STOP_CONTROLLER_DEFINES_SVH
`define ENCODER_POSITION_STOP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EPSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/epsc_pkg.sv
// Shared types and constants of the encoder position stop controller.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none

package epsc_pkg;

   // fixed payload widths
   localparam int TARGET_BITS    = 16;
   localparam int POS_OUT_BITS   = 16;
   localparam int PCT_BITS       = 7;
   localparam int STALL_BITS     = 16;
   localparam int OPCODE_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // reset values of the registers
   localparam logic [STALL_BITS-1:0] STALL_RESET = 16'd200;
   localparam logic [PCT_BITS-1:0]   FULL_RESET  = 7'd100;
   localparam logic [PCT_BITS-1:0]   CREEP_RESET = 7'd20;
   localparam logic [PCT_BITS-1:0]   PCT_MAX     = 7'd100;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_TICK  = 2'd0,
      OP_EDGE  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STALL_TICKS = 2'd0,
      CSR_FULL_POWER  = 2'd1,
      CSR_CREEP_POWER = 2'd2
   } csr_index_type;

   // H-bridge codes: bit 1 drives input A, bit 0 drives input B
   typedef enum logic [1:0] {
      BR_BACK  = 2'b01,
      BR_FWD   = 2'b10,
      BR_BRAKE = 2'b11
   } bridge_type;

   typedef struct packed {
      logic [STALL_BITS-1:0] stall_ticks;
      logic [PCT_BITS-1:0]   full_power;
      logic [PCT_BITS-1:0]   creep_power;
   } cfg_type;

   typedef struct packed {
      logic                           bridge_a;
      logic                           bridge_b;
      logic [PCT_BITS-1:0]            drive_percent;
      logic signed [POS_OUT_BITS-1:0] position;
      logic                           busy_res;
      logic                           done_res;
   } result_type;

   // limit a percent register to 100
   function automatic logic [PCT_BITS-1:0] clamp_pct(input logic [PCT_BITS-1:0] p);
      clamp_pct = (p > PCT_MAX) ? PCT_MAX : p;
   endfunction

endpackage

`default_nettype wire

>>> src/epsc_req_if.sv
// Request channel of the stop controller: valid, ready and one input item.
// Depends on epsc_pkg for field widths.
`default_nettype none

interface epsc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [epsc_pkg::OPCODE_BITS-1:0]        opcode;
   logic signed [epsc_pkg::TARGET_BITS-1:0] target_position;

   modport source (output valid, output opcode, output target_position, input ready);
   modport sink   (input valid, input opcode, input target_position, output ready);
endinterface

`default_nettype wire

>>> src/epsc_rsp_if.sv
// Response channel of the stop controller: valid, ready and one result item.
// Depends on epsc_pkg for field widths.
`default_nettype none

interface epsc_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     bridge_a;
   logic                                     bridge_b;
   logic [epsc_pkg::PCT_BITS-1:0]            drive_percent;
   logic signed [epsc_pkg::POS_OUT_BITS-1:0] position;
   logic                                     busy_res;
   logic                                     done_res;

   modport source (output valid, output bridge_a, output bridge_b, output drive_percent,
                   output position, output busy_res, output done_res, input ready);
   modport sink   (input valid, input bridge_a, input bridge_b, input drive_percent,
                   input position, input busy_res, input done_res, output ready);
endinterface

`default_nettype wire

>>> src/epsc_core.sv
// Motion state of the stop controller and its single-pass update per item.
// Depends on epsc_pkg; instantiated by encoder_position_stop_controller.
`default_nettype none

module epsc_core #(
   parameter int POSITION_BITS = 16,
   parameter int IDLE_BITS     = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    item_fire,
   input  epsc_pkg::opcode_type                    opcode,
   input  logic signed [epsc_pkg::TARGET_BITS-1:0] target_position,
   input  epsc_pkg::cfg_type                       cfg,
   output epsc_pkg::result_type                    result
);
   import epsc_pkg::*;

   localparam int CMP_BITS = (IDLE_BITS > STALL_BITS) ? IDLE_BITS : STALL_BITS;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] goal_ff, goal_in;
   logic                     down_ff, down_in;
   logic [IDLE_BITS-1:0]     idle_ff, idle_in;
   logic                     moving_ff, moving_in;
   bridge_type               bridge_ff, bridge_in;
   logic [PCT_BITS-1:0]      power_ff, power_in;
   logic                     done;

   logic [POSITION_BITS-1:0] target_ext;
   logic [IDLE_BITS-1:0]     idle_inc;
   logic                     pos_above_goal;
   logic                     target_below_pos;
   logic                     stalled;

   // sign-extend or wrap the target to the position width
   assign target_ext       = POSITION_BITS'(target_position);
   assign pos_above_goal   = $signed(pos_ff) > $signed(goal_ff);
   assign target_below_pos = $signed(target_ext) < $signed(pos_ff);

   // saturating idle count after a tick, and the stall test on it
   assign idle_inc = (idle_ff != {IDLE_BITS{1'b1}}) ? (idle_ff + IDLE_BITS'(1)) : idle_ff;
   assign stalled  = moving_ff && (CMP_BITS'(idle_inc) > CMP_BITS'(cfg.stall_ticks));

   // next state for the current item
   always_comb begin
      pos_in    = pos_ff;
      goal_in   = goal_ff;
      down_in   = down_ff;
      idle_in   = idle_ff;
      moving_in = moving_ff;
      bridge_in = bridge_ff;
      power_in  = power_ff;
      done      = 1'b0;
      case (opcode)
         OP_TICK: begin
            idle_in = idle_inc;
            if (stalled) begin
               if (pos_ff == goal_ff) begin
                  moving_in = 1'b0;
                  done      = 1'b1;
               end else if (pos_above_goal != down_ff) begin
                  // overshoot: reverse and creep back
                  down_in   = pos_above_goal;
                  bridge_in = pos_above_goal ? BR_BACK : BR_FWD;
                  power_in  = clamp_pct(cfg.creep_power);
               end
            end
         end
         OP_EDGE: begin
            pos_in  = down_ff ? (pos_ff - POSITION_BITS'(1)) : (pos_ff + POSITION_BITS'(1));
            idle_in = '0;
            if (pos_in == goal_ff) begin
               bridge_in = BR_BRAKE;
               power_in  = PCT_MAX;
            end
         end
         OP_START: begin
            goal_in = target_ext;
            idle_in = '0;
            if (target_ext == pos_ff) begin
               bridge_in = BR_BRAKE;
               power_in  = PCT_MAX;
               moving_in = 1'b0;
               done      = 1'b1;
            end else begin
               down_in   = target_below_pos;
               bridge_in = target_below_pos ? BR_BACK : BR_FWD;
               power_in  = clamp_pct(cfg.full_power);
               moving_in = 1'b1;
            end
         end
         default: begin
            // no event: report status only
         end
      endcase
   end

   // hold state, advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         goal_ff   <= '0;
         down_ff   <= 1'b0;
         idle_ff   <= '0;
         moving_ff <= 1'b0;
         bridge_ff <= BR_BRAKE;
         power_ff  <= PCT_MAX;
      end else if (item_fire) begin
         pos_ff    <= pos_in;
         goal_ff   <= goal_in;
         down_ff   <= down_in;
         idle_ff   <= idle_in;
         moving_ff <= moving_in;
         bridge_ff <= bridge_in;
         power_ff  <= power_in;
      end
   end

   // result fields from the updated state
   always_comb begin
      result.bridge_a      = bridge_in[1];
      result.bridge_b      = bridge_in[0];
      result.drive_percent = power_in;
      result.position      = POS_OUT_BITS'($signed(pos_in));
      result.busy_res      = moving_in;
      result.done_res      = done;
   end

endmodule

`default_nettype wire

>>> src/encoder_position_stop_controller.sv
// Top level of the encoder position stop controller: config registers and result register.
// Depends on epsc_pkg, epsc_req_if, epsc_rsp_if and epsc_core.
//
//   channel    dir   handshake        carries
//   req_chan   in    valid / ready    opcode, target_position
//   rsp_chan   out   valid / ready    bridge_a, bridge_b, drive_percent, position,
//                                     busy_res, done_res
//   csr_*      in    write enable     register index, write data
//
// One item per cycle while the result register is empty or draining: the state
// update is one pass of compare and add logic in epsc_core, and its result is
// registered in a single result register. Every accepted item gives exactly one result.
// Reset (synchronous, active high) brakes the motor, clears position, goal and idle
// count, and loads the register defaults 200, 100 and 20.
// A stalled result register still takes a new item in the cycle its result is taken.
`default_nettype none

module encoder_position_stop_controller #(
   parameter int POSITION_BITS = 16,
   parameter int IDLE_BITS     = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   epsc_req_if.sink                                 req_chan,
   epsc_rsp_if.source                               rsp_chan,
   input  logic                                     csr_write_enable,
   input  logic [epsc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [epsc_pkg::CSR_DATA_BITS-1:0]       csr_write_data
);
   import epsc_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       item_fire;

   // take a new transaction whenever the result register is empty or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign item_fire      = req_chan.valid && req_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_ticks <= STALL_RESET;
         cfg_ff.full_power  <= FULL_RESET;
         cfg_ff.creep_power <= CREEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_STALL_TICKS: cfg_ff.stall_ticks <= STALL_BITS'(csr_write_data);
            CSR_FULL_POWER:  cfg_ff.full_power  <= PCT_BITS'(csr_write_data);
            CSR_CREEP_POWER: cfg_ff.creep_power <= PCT_BITS'(csr_write_data);
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   epsc_core #(
      .POSITION_BITS (POSITION_BITS),
      .IDLE_BITS     (IDLE_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .item_fire       (item_fire),
      .opcode          (opcode_type'(req_chan.opcode)),
      .target_position (req_chan.target_position),
      .cfg             (cfg_ff),
      .result          (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.bridge_a      = rsp_data_ff.bridge_a;
   assign rsp_chan.bridge_b      = rsp_data_ff.bridge_b;
   assign rsp_chan.drive_percent = rsp_data_ff.drive_percent;
   assign rsp_chan.position      = rsp_data_ff.position;
   assign rsp_chan.busy_res      = rsp_data_ff.busy_res;
   assign rsp_chan.done_res      = rsp_data_ff.done_res;

endmodule

`default_nettype wire

>>> src/epsc_checker.sv
// Port-level checks of the stop controller, bound to the top level.
// Depends on epsc_req_if, epsc_rsp_if and the assertion macro header.
`default_nettype none
`include "encoder_position_stop_controller_defines.svh"

module epsc_checker (
   input logic        clock,
   input logic        reset,
   epsc_req_if.sink   req_chan,
   epsc_rsp_if.source rsp_chan
);

   // an accepted transaction always produces a result next cycle
   `EPSC_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_chan.valid && req_chan.ready, rsp_chan.valid, "accepted item gave no result")

   // a completed move is never still busy
   `EPSC_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_chan.valid && rsp_chan.done_res, !rsp_chan.busy_res, "done reported while busy")

   // braking always runs at full enable; driving never exceeds 100 percent
   `EPSC_ASSERT_NOW(a_brake_power, clock, reset, rsp_chan.valid && rsp_chan.bridge_a && rsp_chan.bridge_b, rsp_chan.drive_percent == 7'd100, "brake without full enable")

   `EPSC_ASSERT_NOW(a_power_range, clock, reset, rsp_chan.valid, (rsp_chan.drive_percent <= 7'd100) && (rsp_chan.bridge_a || rsp_chan.bridge_b), "bad bridge code or drive percent")

   // a stalled result holds
   `EPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_chan.position) && $stable(rsp_chan.drive_percent), "stalled result changed")

endmodule

bind encoder_position_stop_controller epsc_checker u_epsc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
